// ----- design/midi_byte_stream_parser_core_macros.svh -----
// Assertion macros used by the MIDI byte stream parser RTL.
// No dependencies; include guard below.
`ifndef MIDI_BYTE_STREAM_PARSER_CORE_MACROS_SVH
`define MIDI_BYTE_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsp assertion failed (same cycle)");

// Next-cycle implication, disabled in reset.
`define MBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsp assertion failed (next cycle)");

`endif

// ----- design/mbsp_pkg.sv -----
// Package for the MIDI byte stream parser: types, status codes, length decode.
// No dependencies.
`default_nettype none

package mbsp_pkg;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_PARAM = 2'd1,
        MODE_SYSEX = 2'd2,
        MODE_ERROR = 2'd3
    } mode_t;

    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic [7:0] STATUS_PROG  = 8'hC0;
    localparam logic [7:0] STATUS_BEND  = 8'hE0;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYS_MTC      = 8'hF1;
    localparam logic [7:0] SYS_SONG_POS = 8'hF2;
    localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
    localparam logic [7:0] SYSEX_END    = 8'hF7;

    localparam int unsigned SYSEX_WORD_BYTES = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic        err;
    } result_t;

    // Total message length in bytes for a status byte; 0 for data bytes and SysEx start.
    function automatic logic [1:0] msg_length(input logic [7:0] s);
        logic [1:0] len;
        begin
            if (s < STATUS_MIN)
                len = 2'd0;
            else if (s < STATUS_PROG)
                len = 2'd3;
            else if (s < STATUS_BEND)
                len = 2'd2;
            else if (s < SYSEX_START)
                len = 2'd3;
            else if (s == SYSEX_START)
                len = 2'd0;
            else if (s == SYS_MTC || s == SYS_SONG_SEL)
                len = 2'd2;
            else if (s == SYS_SONG_POS)
                len = 2'd3;
            else
                len = 2'd1;
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/mbsp_in_stage.sv -----
// Input register of the MIDI byte stream parser.
// Depends on mbsp_pkg.
`default_nettype none

module mbsp_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    output logic                 byte_ready,
    input  wire logic [7:0]      data_byte,
    input  wire logic            buffer_end,
    input  wire logic            take,
    output logic                 item_valid,
    output mbsp_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    mbsp_pkg::item_t item_reg;

    assign byte_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && byte_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= buffer_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/mbsp_decode.sv -----
// Parser state and per-byte decode of the MIDI byte stream parser.
// Depends on mbsp_pkg and midi_byte_stream_parser_core_macros.svh.
`default_nettype none
`include "midi_byte_stream_parser_core_macros.svh"

module mbsp_decode
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire mbsp_pkg::item_t item,
    output mbsp_pkg::result_t    res
);

    mbsp_pkg::mode_t mode_reg;
    mbsp_pkg::mode_t mode_next;
    logic [7:0]      held_status_reg;
    logic [7:0]      held_status_next;
    logic [7:0]      first_param_reg;
    logic [7:0]      first_param_next;
    logic [1:0]      need_reg;
    logic [1:0]      need_next;
    logic [23:0]     sysex_bytes_reg;
    logic [23:0]     sysex_bytes_next;
    logic [1:0]      sysex_count_reg;
    logic [1:0]      sysex_count_next;

    logic [1:0]      len;
    logic            held_len3;
    logic [31:0]     sysex_word;
    logic [2:0]      sysex_n;
    logic            sysex_flush;

    assign len         = mbsp_pkg::msg_length(item.data);
    assign held_len3   = mbsp_pkg::msg_length(held_status_reg) == 2'd3;
    assign sysex_word  = {8'd0, sysex_bytes_reg} | ({24'd0, item.data} << {sysex_count_reg, 3'b000});
    assign sysex_n     = {1'b0, sysex_count_reg} + 3'd1;
    assign sysex_flush = (item.data == mbsp_pkg::SYSEX_END)
                         || (sysex_n == 3'(mbsp_pkg::SYSEX_WORD_BYTES));

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            unique case (mode_reg)
                mbsp_pkg::MODE_READY:
                begin
                    if (item.data < mbsp_pkg::STATUS_MIN)
                        mode_next = mbsp_pkg::MODE_ERROR;
                    else if (item.data == mbsp_pkg::SYSEX_START)
                        mode_next = mbsp_pkg::MODE_SYSEX;
                    else if (len > 2'd1)
                        mode_next = item.last ? mbsp_pkg::MODE_ERROR : mbsp_pkg::MODE_PARAM;
                end
                mbsp_pkg::MODE_PARAM:
                begin
                    if (need_reg[1])
                    begin
                        if (item.last)
                            mode_next = mbsp_pkg::MODE_ERROR;
                    end
                    else
                        mode_next = mbsp_pkg::MODE_READY;
                end
                mbsp_pkg::MODE_SYSEX:
                begin
                    if (item.data == mbsp_pkg::SYSEX_END)
                        mode_next = mbsp_pkg::MODE_READY;
                end
                mbsp_pkg::MODE_ERROR:
                    mode_next = mbsp_pkg::MODE_ERROR;
                default:
                    mode_next = mode_reg;
            endcase
        end
    end

    // outputs and datapath
    always_comb
    begin
        held_status_next = held_status_reg;
        first_param_next = first_param_reg;
        need_next        = need_reg;
        sysex_bytes_next = sysex_bytes_reg;
        sysex_count_next = sysex_count_reg;
        res              = '0;
        if (step)
        begin
            unique case (mode_reg)
                mbsp_pkg::MODE_READY:
                begin
                    if (item.data < mbsp_pkg::STATUS_MIN)
                    begin
                        res.valid = 1'b1;
                        res.err   = 1'b1;
                    end
                    else if (item.data == mbsp_pkg::SYSEX_START)
                    begin
                        sysex_bytes_next = {16'd0, mbsp_pkg::SYSEX_START};
                        sysex_count_next = 2'd1;
                    end
                    else if (len <= 2'd1)
                    begin
                        res.valid = 1'b1;
                        res.word  = {24'd0, item.data};
                    end
                    else
                    begin
                        held_status_next = item.data;
                        first_param_next = 8'd0;
                        need_next        = len - 2'd1;
                        if (item.last)
                        begin
                            res.valid = 1'b1;
                            res.err   = 1'b1;
                        end
                    end
                end
                mbsp_pkg::MODE_PARAM:
                begin
                    if (need_reg[1])
                    begin
                        first_param_next = item.data;
                        need_next        = 2'd1;
                        if (item.last)
                        begin
                            res.valid = 1'b1;
                            res.err   = 1'b1;
                        end
                    end
                    else
                    begin
                        need_next = 2'd0;
                        res.valid = 1'b1;
                        if (held_len3)
                            res.word = {8'd0, item.data, first_param_reg, held_status_reg};
                        else
                            res.word = {16'd0, item.data, held_status_reg};
                    end
                end
                mbsp_pkg::MODE_SYSEX:
                begin
                    if (sysex_flush)
                    begin
                        sysex_bytes_next = 24'd0;
                        sysex_count_next = 2'd0;
                        res.valid        = 1'b1;
                        res.word         = sysex_word;
                    end
                    else
                    begin
                        sysex_bytes_next = sysex_word[23:0];
                        sysex_count_next = sysex_n[1:0];
                    end
                end
                mbsp_pkg::MODE_ERROR:
                    res = '0;
                default:
                    res = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= mbsp_pkg::MODE_READY;
            held_status_reg <= 8'd0;
            first_param_reg <= 8'd0;
            need_reg        <= 2'd0;
            sysex_bytes_reg <= 24'd0;
            sysex_count_reg <= 2'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            held_status_reg <= held_status_next;
            first_param_reg <= first_param_next;
            need_reg        <= need_next;
            sysex_bytes_reg <= sysex_bytes_next;
            sysex_count_reg <= sysex_count_next;
        end
    end

    `MBSP_ASSERT_NEXT(a_error_sticky, clk, rst_n, mode_reg == mbsp_pkg::MODE_ERROR, mode_reg == mbsp_pkg::MODE_ERROR)
    `MBSP_ASSERT_IMPL(a_error_silent, clk, rst_n, mode_reg == mbsp_pkg::MODE_ERROR, !res.valid)
    `MBSP_ASSERT_IMPL(a_error_word_zero, clk, rst_n, res.valid && res.err, res.word == 32'd0)
    `MBSP_ASSERT_IMPL(a_param_pending, clk, rst_n, mode_reg == mbsp_pkg::MODE_PARAM, need_reg != 2'd0)
    `MBSP_ASSERT_IMPL(a_sysex_idle_clear, clk, rst_n, mode_reg != mbsp_pkg::MODE_SYSEX, sysex_count_reg == 2'd0)

endmodule

`default_nettype wire

// ----- design/mbsp_out_stage.sv -----
// Result register of the MIDI byte stream parser.
// Depends on mbsp_pkg.
`default_nettype none

module mbsp_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbsp_pkg::result_t res,
    output logic                   can_load,
    output logic                   msg_valid,
    input  wire logic              msg_ready,
    output logic [31:0]            message_word,
    output logic                   error_flag
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        err_reg;

    assign can_load = !valid_reg || msg_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
            valid_next = 1'b1;
        else if (msg_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            word_reg <= res.word;
            err_reg  <= res.err;
        end
    end

    assign msg_valid    = valid_reg;
    assign message_word = word_reg;
    assign error_flag   = err_reg;

endmodule

`default_nettype wire

// ----- design/midi_byte_stream_parser_core.sv -----
// MIDI byte stream parser: takes one byte per transaction and returns packed channel and
// system messages, SysEx words of up to four bytes, or a single error report. Sustained
// rate is one byte per clock while msg_ready stays high. A byte's result reaches the
// outputs through the input register, the single decode stage and the result register.
// While a result waits unaccepted, the byte in the input register waits with it, so a
// stalled receiver stalls the input once the input register holds a byte. A byte that
// completes nothing yields no result. Depends on mbsp_pkg, mbsp_in_stage, mbsp_decode,
// mbsp_out_stage.
`default_nettype none

module midi_byte_stream_parser_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,
    output logic             msg_valid,
    input  wire logic        msg_ready,
    output logic [31:0]      message_word,
    output logic             error_flag
);

    logic              item_valid;
    mbsp_pkg::item_t   item;
    logic              can_load;
    logic              step;
    mbsp_pkg::result_t res;

    assign step = item_valid && can_load;

    mbsp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    mbsp_decode u_decode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .res   (res)
    );

    mbsp_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .can_load     (can_load),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .message_word (message_word),
        .error_flag   (error_flag)
    );

endmodule

`default_nettype wire
